FILE: rtl/mahalanobis_gated_association_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the gated association core
// Implication shorthands used by the checker.
// ----------------------------------------------------------------------------
`ifndef MAHALANOBIS_GATED_ASSOCIATION_CORE_ASSERT_SVH
`define MAHALANOBIS_GATED_ASSOCIATION_CORE_ASSERT_SVH

// same-cycle implication
`define MGA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mga assertion failed");

// next-cycle implication
`define MGA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mga assertion failed");

`endif

FILE: rtl/mga_pkg.sv
// ----------------------------------------------------------------------------
// mga_pkg
// Shared types and constants of the gated association core.
// ----------------------------------------------------------------------------
package mga_pkg;

   localparam int MAX_BEACONS = 64;
   localparam int ADDR_W      = $clog2(MAX_BEACONS);
   localparam int CNT_W       = $clog2(MAX_BEACONS + 1);

   localparam logic [31:0] GATE_RESET = 32'd603609;
   localparam logic [31:0] DIST_SAT   = 32'hFFFF_FFFF;

   localparam logic [1:0] OP_CLEAR   = 2'd0;
   localparam logic [1:0] OP_APPEND  = 2'd1;
   localparam logic [1:0] OP_OBSERVE = 2'd2;

   typedef struct packed {
      logic [15:0] gid;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] var_xx;
      logic [31:0] var_xy;
      logic [31:0] var_yy;
   } beacon_type;

   localparam int BEACON_W = $bits(beacon_type);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_READ,
      ST_PREP,
      ST_AC,
      ST_BB,
      ST_DX2,
      ST_CX0,
      ST_CX1,
      ST_DY2,
      ST_AY0,
      ST_AY1,
      ST_XY,
      ST_BX0,
      ST_BX1,
      ST_BX2,
      ST_CHK,
      ST_DIV,
      ST_UPD,
      ST_DONE
   } state_type;

endpackage

FILE: rtl/mga_if.sv
// ----------------------------------------------------------------------------
// mga request / response channels
// Valid/ready channels carrying the command and the association result.
// ----------------------------------------------------------------------------
interface mga_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [15:0] landmark_id;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic [31:0] var_xx;
   logic signed [31:0] var_xy;
   logic [31:0] var_yy;

   modport source (output valid, opcode, landmark_id, pos_x, pos_y, var_xx, var_xy,
                   var_yy, input ready);
   modport sink (input valid, opcode, landmark_id, pos_x, pos_y, var_xx, var_xy,
                 var_yy, output ready);
endinterface

interface mga_rsp_if;
   logic        valid;
   logic        ready;
   logic        matched;
   logic [15:0] match_id;
   logic [31:0] best_distance;

   modport source (output valid, matched, match_id, best_distance, input ready);
   modport sink (input valid, matched, match_id, best_distance, output ready);
endinterface

FILE: rtl/mga_ram.sv
// ----------------------------------------------------------------------------
// mga_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mga_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/mahalanobis_gated_association_core.sv
// ----------------------------------------------------------------------------
// mahalanobis_gated_association_core
// Nearest-neighbour gated association of 2-D landmarks in Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//  req_chan  : valid/ready command channel. opcode clear empties the beacon
//              table, append stores one beacon (ignored when full), observe
//              scans the table. Code 3 is dropped. Clear and append produce
//              no response.
//  rsp_chan  : one transaction per observe: matched, match_id, best_distance.
//  csr_we/csr_wdata : gate threshold write, Q16.16, strictly-below compare.
// An observe scans every beacon in the table; singular beacons exit after
//  the determinant check, saturated distances skip the divider. The scan uses
//  one 34x34 multiplier for eleven products per beacon and a restoring
//  divider retiring one quotient bit per cycle. One item is in flight; the
//  block is not ready while it scans.
// Reset: table count cleared (table contents stay undefined), gate reloaded.
// Stall: the result waits in an output register; further clear/append
//  commands are still taken, and a new observe runs its scan but holds its
//  result (and the input) until the previous result drains.
// ----------------------------------------------------------------------------
module mahalanobis_gated_association_core
   import mga_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   mga_req_if.sink     req_chan,
   mga_rsp_if.source   rsp_chan
);

   // control
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   k_ff, k_in;
   logic [31:0]        gate_ff;
   logic               found_ff, found_in;
   logic [4:0]         bit_ff, bit_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // observation
   logic signed [31:0] ox_ff, oy_ff, oxy_ff;
   logic [31:0]        oxx_ff, oyy_ff;

   // per-beacon datapath
   logic [31:0]        adx_ff, adx_in, ady_ff, ady_in;
   logic [32:0]        a_ff, a_in, c_ff, c_in, ab_ff, ab_in;
   logic               neg_ff, neg_in;
   logic [15:0]        gid_ff, gid_in;
   logic [67:0]        prod_ff;
   logic [65:0]        ac_ff, ac_in, den_ff, den_in;
   logic [63:0]        tmp_ff, tmp_in;
   logic [100:0]       acc_ff, acc_in;
   logic [96:0]        dsh_ff, dsh_in;
   logic [31:0]        quo_ff, quo_in;
   logic [31:0]        best_ff, best_in;
   logic [15:0]        best_gid_ff, best_gid_in;

   // response payload
   logic               rsp_matched_ff, rsp_matched_in;
   logic [15:0]        rsp_id_ff, rsp_id_in;
   logic [31:0]        rsp_dist_ff, rsp_dist_in;

   // shared multiplier
   logic [33:0]        mul_a, mul_b;
   logic [67:0]        prod_in;

   // table
   logic               wr_en, rd_en;
   beacon_type         wr_bcn, rd_bcn;
   logic [BEACON_W-1:0] rd_raw;

   logic               accept;
   logic signed [32:0] dx, dy, bsum;
   logic [100:0]       prod_sh;
   logic [100:0]       prod_ext;
   logic               div_ge;
   logic [CNT_W-1:0]   k_next;

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   assign wr_bcn = '{gid: req_chan.landmark_id, x: req_chan.pos_x, y: req_chan.pos_y,
                     var_xx: req_chan.var_xx, var_xy: req_chan.var_xy,
                     var_yy: req_chan.var_yy};
   assign wr_en  = accept && (req_chan.opcode == OP_APPEND)
                   && (count_ff < CNT_W'(MAX_BEACONS));
   assign rd_en  = (state_ff == ST_READ);
   assign rd_bcn = beacon_type'(rd_raw);

   mga_ram #(.WIDTH(BEACON_W), .DEPTH(MAX_BEACONS)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (wr_bcn),
      .rd_en   (rd_en),
      .rd_addr (k_ff[ADDR_W-1:0]),
      .rd_data (rd_raw)
   );

   // offsets and summed covariance of the beacon just read
   assign dx   = {rd_bcn.x[31], rd_bcn.x} - {ox_ff[31], ox_ff};
   assign dy   = {rd_bcn.y[31], rd_bcn.y} - {oy_ff[31], oy_ff};
   assign bsum = {rd_bcn.var_xy[31], rd_bcn.var_xy} + {oxy_ff[31], oxy_ff};

   assign prod_in  = mul_a * mul_b;
   assign prod_ext = {33'd0, prod_ff};
   assign prod_sh  = {1'b0, prod_ff, 32'd0};
   assign div_ge   = (acc_ff >= {4'd0, dsh_ff});
   assign k_next   = k_ff + CNT_W'(1);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      k_in           = k_ff;
      found_in       = found_ff;
      bit_in         = bit_ff;
      adx_in         = adx_ff;
      ady_in         = ady_ff;
      a_in           = a_ff;
      c_in           = c_ff;
      ab_in          = ab_ff;
      neg_in         = neg_ff;
      gid_in         = gid_ff;
      ac_in          = ac_ff;
      den_in         = den_ff;
      tmp_in         = tmp_ff;
      acc_in         = acc_ff;
      dsh_in         = dsh_ff;
      quo_in         = quo_ff;
      best_in        = best_ff;
      best_gid_in    = best_gid_ff;
      rsp_matched_in = rsp_matched_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_dist_in    = rsp_dist_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      mul_a          = '0;
      mul_b          = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_chan.opcode)
                  OP_CLEAR: count_in = '0;
                  OP_APPEND: begin
                     if (wr_en) begin
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_OBSERVE: begin
                     k_in     = '0;
                     found_in = 1'b0;
                     best_in  = DIST_SAT;
                     state_in = (count_ff == '0) ? ST_DONE : ST_READ;
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: state_in = ST_PREP;
         ST_PREP: begin
            adx_in   = dx[32] ? 32'(-dx) : dx[31:0];
            ady_in   = dy[32] ? 32'(-dy) : dy[31:0];
            a_in     = {1'b0, rd_bcn.var_xx} + {1'b0, oxx_ff};
            c_in     = {1'b0, rd_bcn.var_yy} + {1'b0, oyy_ff};
            ab_in    = bsum[32] ? 33'(-bsum) : bsum;
            neg_in   = bsum[32] ^ dx[32] ^ dy[32];
            gid_in   = rd_bcn.gid;
            state_in = ST_AC;
         end
         ST_AC: begin
            mul_a    = {1'b0, a_ff};
            mul_b    = {1'b0, c_ff};
            state_in = ST_BB;
         end
         ST_BB: begin
            ac_in    = prod_ff[65:0];
            mul_a    = {1'b0, ab_ff};
            mul_b    = {1'b0, ab_ff};
            state_in = ST_DX2;
         end
         ST_DX2: begin
            // prod holds b^2: a singular summed covariance skips the beacon
            mul_a = {2'd0, adx_ff};
            mul_b = {2'd0, adx_ff};
            if (prod_ff >= {2'd0, ac_ff}) begin
               k_in     = k_next;
               state_in = (k_next == count_ff) ? ST_DONE : ST_READ;
            end else begin
               den_in   = ac_ff - prod_ff[65:0];
               state_in = ST_CX0;
            end
         end
         ST_CX0: begin
            tmp_in   = prod_ff[63:0];
            mul_a    = {1'b0, c_ff};
            mul_b    = {2'd0, prod_ff[31:0]};
            state_in = ST_CX1;
         end
         ST_CX1: begin
            acc_in   = prod_ext;
            mul_a    = {1'b0, c_ff};
            mul_b    = {2'd0, tmp_ff[63:32]};
            state_in = ST_DY2;
         end
         ST_DY2: begin
            acc_in   = acc_ff + prod_sh;
            mul_a    = {2'd0, ady_ff};
            mul_b    = {2'd0, ady_ff};
            state_in = ST_AY0;
         end
         ST_AY0: begin
            tmp_in   = prod_ff[63:0];
            mul_a    = {1'b0, a_ff};
            mul_b    = {2'd0, prod_ff[31:0]};
            state_in = ST_AY1;
         end
         ST_AY1: begin
            acc_in   = acc_ff + prod_ext;
            mul_a    = {1'b0, a_ff};
            mul_b    = {2'd0, tmp_ff[63:32]};
            state_in = ST_XY;
         end
         ST_XY: begin
            acc_in   = acc_ff + prod_sh;
            mul_a    = {2'd0, adx_ff};
            mul_b    = {2'd0, ady_ff};
            state_in = ST_BX0;
         end
         ST_BX0: begin
            tmp_in   = prod_ff[63:0];
            mul_a    = {ab_ff, 1'b0};
            mul_b    = {2'd0, prod_ff[31:0]};
            state_in = ST_BX1;
         end
         ST_BX1: begin
            // cross term sign follows b, dx and dy
            acc_in   = neg_ff ? acc_ff + prod_ext : acc_ff - prod_ext;
            mul_a    = {ab_ff, 1'b0};
            mul_b    = {2'd0, tmp_ff[63:32]};
            state_in = ST_BX2;
         end
         ST_BX2: begin
            acc_in   = neg_ff ? acc_ff + prod_sh : acc_ff - prod_sh;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            // quotient would not fit in 32 bits: saturate
            if (acc_ff >= {3'd0, den_ff, 32'd0}) begin
               quo_in   = DIST_SAT;
               state_in = ST_UPD;
            end else begin
               quo_in   = '0;
               dsh_in   = {den_ff, 31'd0};
               bit_in   = 5'd31;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            quo_in = {quo_ff[30:0], div_ge};
            if (div_ge) begin
               acc_in = acc_ff - {4'd0, dsh_ff};
            end
            dsh_in = dsh_ff >> 1;
            bit_in = bit_ff - 5'd1;
            if (bit_ff == 5'd0) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            // strict compare keeps the earliest beacon on ties
            if (!found_ff || (quo_ff < best_ff)) begin
               found_in    = 1'b1;
               best_in     = quo_ff;
               best_gid_in = gid_ff;
            end
            k_in     = k_next;
            state_in = (k_next == count_ff) ? ST_DONE : ST_READ;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_matched_in = found_ff && (best_ff < gate_ff);
               rsp_id_in      = (found_ff && (best_ff < gate_ff)) ? best_gid_ff : 16'd0;
               rsp_dist_in    = best_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         gate_ff      <= GATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            gate_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (req_chan.opcode == OP_OBSERVE)) begin
         ox_ff  <= req_chan.pos_x;
         oy_ff  <= req_chan.pos_y;
         oxx_ff <= req_chan.var_xx;
         oxy_ff <= req_chan.var_xy;
         oyy_ff <= req_chan.var_yy;
      end
      k_ff           <= k_in;
      found_ff       <= found_in;
      bit_ff         <= bit_in;
      adx_ff         <= adx_in;
      ady_ff         <= ady_in;
      a_ff           <= a_in;
      c_ff           <= c_in;
      ab_ff          <= ab_in;
      neg_ff         <= neg_in;
      gid_ff         <= gid_in;
      prod_ff        <= prod_in;
      ac_ff          <= ac_in;
      den_ff         <= den_in;
      tmp_ff         <= tmp_in;
      acc_ff         <= acc_in;
      dsh_ff         <= dsh_in;
      quo_ff         <= quo_in;
      best_ff        <= best_in;
      best_gid_ff    <= best_gid_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_dist_ff    <= rsp_dist_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.matched       = rsp_matched_ff;
   assign rsp_chan.match_id      = rsp_id_ff;
   assign rsp_chan.best_distance = rsp_dist_ff;

endmodule

FILE: rtl/mga_checker.sv
// ----------------------------------------------------------------------------
// mga_checker
// Port-level checks on the gated association core, bound to the top level.
// ----------------------------------------------------------------------------
`include "mahalanobis_gated_association_core_assert.svh"

module mga_checker
   import mga_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_opcode,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_matched,
   input logic [15:0] rsp_match_id,
   input logic [31:0] rsp_best_distance
);

   `MGA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `MGA_ASSERT_NEXT(a_observe_busy, clock, reset,
      req_valid && req_ready && (req_opcode == OP_OBSERVE), !req_ready)
   `MGA_ASSERT_IMPL(a_nomatch_id, clock, reset, rsp_valid && !rsp_matched,
      rsp_match_id == 16'd0)
   `MGA_ASSERT_IMPL(a_match_dist, clock, reset, rsp_valid && rsp_matched,
      rsp_best_distance != DIST_SAT)

endmodule

bind mahalanobis_gated_association_core mga_checker u_mga_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .req_opcode        (req_chan.opcode),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_matched       (rsp_chan.matched),
   .rsp_match_id      (rsp_chan.match_id),
   .rsp_best_distance (rsp_chan.best_distance)
);
